// ===== rtl/masked_byte_pattern_scanner_unit_macros.svh =====
// assertion helpers for the checker file
`ifndef MASKED_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_UNIT_MACROS_SVH

// property checked outside reset
`define MBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define MBPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

  // sizing
  localparam int MaxPattern = 16;
  localparam int OffsetBits = 32;
  localparam int WinDepth   = MaxPattern - 1;
  localparam int PosW       = OffsetBits + 1;
  localparam int SelW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int LenW       = 5;
  localparam int MaskW      = 16;
  localparam int CntW       = 16;
  localparam int OffW       = 32;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 3;
  localparam int QDepth     = 4;
  localparam int QPtrW      = $clog2(QDepth);

  // register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_HIGH = 3'd1,
    CFG_MASK     = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_LIMIT    = 3'd4
  } cfg_idx_e;

  // result kinds
  localparam logic KindMatch   = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } scan_in_t;

  typedef struct packed {
    logic            result_kind;
    logic [OffW-1:0] match_offset;
    logic [CntW-1:0] match_count;
    logic            last_result;
  } scan_out_t;

  // one classified item between front and back
  typedef struct packed {
    logic            report;
    logic            eob;
    logic [OffW-1:0] offset;
    logic [CntW-1:0] count;
  } mbps_work_t;

endpackage

// ===== rtl/masked_byte_pattern_scanner_unit.sv =====
// a taken byte's results are written to the work queue and then to the output register
// throughput: one byte per cycle while full is low; a byte that ends a buffer with a
//   match yields two results and holds the back for both, which the four-entry queue
//   absorbs; a steady run of such bytes fills it and slows the input
// full rises only when that queue is full; the output drains one result a cycle on pop
// reset: registers to defaults (match limit 1), window, position, count and queue cleared
module masked_byte_pattern_scanner_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  mbps_pkg::scan_in_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output mbps_pkg::scan_out_t           out_item_o
);
  import mbps_pkg::*;

  logic       accept, work_valid, head_valid, head_pop;
  mbps_work_t work, head;

  assign accept = push && !full;

  // front: configuration and match classification
  mbps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .work_valid_o (work_valid),
    .work_o       (work)
  );

  // queue between front and back
  mbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_valid),
    .wdata_i (work),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  // back: result expansion and output register
  mbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_o        (out_item_o)
  );

endmodule

// ===== rtl/mbps_front.sv =====
module mbps_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            accept_i,
  input  mbps_pkg::scan_in_t              item_i,
  output logic                            work_valid_o,
  output mbps_pkg::mbps_work_t            work_o
);
  import mbps_pkg::*;

  logic [63:0]       pat_low_q, pat_high_q;
  logic [MaskW-1:0]  mask_q;
  logic [LenW-1:0]   len_q;
  logic [CntW-1:0]   limit_q;

  logic [7:0]        win_q [WinDepth];
  logic [PosW-1:0]   pos_q;
  logic [CntW-1:0]   found_q;

  logic [127:0]      pat_all;
  logic [7:0]        seq   [MaxPattern];
  logic [MaxPattern-1:0] care, cmp_ok;
  logic              len_ok, enough, start_ok, hit, report;
  logic [PosW:0]     pos_inc, start;
  logic [CntW-1:0]   cnt_next;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      mask_q     <= '0;
      len_q      <= '0;
      limit_q    <= CntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAT_LOW:  pat_low_q  <= cfg_data_i[63:0];
        CFG_PAT_HIGH: pat_high_q <= cfg_data_i[63:0];
        CFG_MASK:     mask_q     <= cfg_data_i[MaskW-1:0];
        CFG_LENGTH:   len_q      <= cfg_data_i[LenW-1:0];
        CFG_LIMIT:    limit_q    <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // byte sequence ending at the current byte, newest first
  assign pat_all = {pat_high_q, pat_low_q};
  always_comb begin
    seq[0] = item_i.data_byte;
    for (int k = 1; k < MaxPattern; k++) begin
      seq[k] = win_q[k-1];
    end
  end

  // one compare lane per pattern byte
  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      logic [LenW-1:0] back;
      back      = len_q - LenW'(j) - LenW'(1);
      care[j]   = (LenW'(j) < len_q) && mask_q[j];
      cmp_ok[j] = !care[j] || (seq[back[SelW-1:0]] == pat_all[8*j +: 8]);
    end
  end

  // match decision and start offset
  assign len_ok   = (len_q != '0) && (len_q <= LenW'(MaxPattern));
  assign pos_inc  = {1'b0, pos_q} + (PosW+1)'(1);
  assign enough   = pos_inc >= (PosW+1)'(len_q);
  assign start    = pos_inc - (PosW+1)'(len_q);
  assign start_ok = (start >> OffsetBits) == '0;
  assign hit      = len_ok && enough && (|care) && (&cmp_ok);
  assign report   = hit && start_ok && (found_q < limit_q);
  assign cnt_next = report ? found_q + CntW'(1) : found_q;

  // classified item toward the queue
  assign work_valid_o  = accept_i && (report || item_i.end_of_buffer);
  assign work_o.report = report;
  assign work_o.eob    = item_i.end_of_buffer;
  assign work_o.offset = OffW'(start);
  assign work_o.count  = cnt_next;

  // scan state: window, position, count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WinDepth; k++) win_q[k] <= '0;
      pos_q   <= '0;
      found_q <= '0;
    end else if (accept_i) begin
      if (item_i.end_of_buffer) begin
        for (int k = 0; k < WinDepth; k++) win_q[k] <= '0;
        pos_q   <= '0;
        found_q <= '0;
      end else begin
        win_q[0] <= item_i.data_byte;
        for (int k = 1; k < WinDepth; k++) win_q[k] <= win_q[k-1];
        if (pos_q != '1) pos_q <= pos_q + PosW'(1);
        found_q <= cnt_next;
      end
    end
  end

endmodule

// ===== rtl/mbps_queue.sv =====
module mbps_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mbps_pkg::mbps_work_t  wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output mbps_pkg::mbps_work_t  rdata_o
);
  import mbps_pkg::*;

  mbps_work_t       slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (QPtrW+1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= wdata_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QPtrW'(1);
      if (do_pop)  rd_q <= rd_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/mbps_back.sv =====
module mbps_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  mbps_pkg::mbps_work_t  head_i,
  output logic                  head_pop_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output mbps_pkg::scan_out_t   out_o
);
  import mbps_pkg::*;

  logic      out_valid_q, out_valid_d;
  scan_out_t out_q, out_d;
  logic      phase_q, phase_d;
  logic      load, emit_match;

  assign load       = !out_valid_q || pop_i;
  assign emit_match = head_i.report && !phase_q;

  // expand a classified item into one or two results
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    phase_d     = phase_q;
    head_pop_o  = 1'b0;
    if (load) begin
      out_valid_d = head_valid_i;
      if (head_valid_i) begin
        if (emit_match) begin
          out_d.result_kind  = KindMatch;
          out_d.match_offset = head_i.offset;
          out_d.match_count  = head_i.count;
          out_d.last_result  = !head_i.eob;
          phase_d            = head_i.eob;
          head_pop_o         = !head_i.eob;
        end else begin
          out_d.result_kind  = KindSummary;
          out_d.match_offset = '0;
          out_d.match_count  = head_i.count;
          out_d.last_result  = 1'b1;
          phase_d            = 1'b0;
          head_pop_o         = 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule

// ===== rtl/mbps_checker.sv =====
`include "masked_byte_pattern_scanner_unit_macros.svh"

module mbps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input mbps_pkg::scan_in_t  in_item_i,
  input logic                empty,
  input logic                pop,
  input mbps_pkg::scan_out_t out_item_o
);
  import mbps_pkg::*;

  // nothing waits on the output right after reset
  `MBPS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> empty, "output not empty after reset")

  // a stalled result holds
  `MBPS_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_item_o), "stalled result changed")

  // a summary closes its byte and carries no offset
  `MBPS_ASSERT(a_summary_form, !empty && (out_item_o.result_kind == KindSummary) |-> out_item_o.last_result && (out_item_o.match_offset == '0), "malformed summary")

  // a match report counts itself
  `MBPS_ASSERT(a_match_count, !empty && (out_item_o.result_kind == KindMatch) |-> out_item_o.match_count != '0, "match report with zero count")

  // a buffer end always yields a waiting result
  `MBPS_ASSERT(a_eob_result, push && !full && in_item_i.end_of_buffer |-> ##2 !empty, "no result after buffer end")

endmodule

bind masked_byte_pattern_scanner_unit mbps_checker u_mbps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_item_i  (in_item_i),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

// ===== tb/masked_byte_pattern_scanner_unit_test.sv =====
module masked_byte_pattern_scanner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int ItemTarget  = 1150;
  localparam int DrainCycles = 8;

  typedef enum int {ROW_WRITE, ROW_BYTE} row_kind_e;

  // one line of the directed table; typed_n < 0 means the predictor decides
  typedef struct {
    row_kind_e       kind;
    cfg_idx_e        idx;
    logic [63:0]     value;
    scan_in_t        item;
    int              typed_n;
    scan_out_t       res0;
    scan_out_t       res1;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                push       = 1'b0;
  logic                full;
  scan_in_t            in_item_i  = '0;
  logic                empty;
  logic                pop        = 1'b0;
  scan_out_t           out_item_o;

  masked_byte_pattern_scanner_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // register shadows
  logic [63:0]     pat_low_r  = '0;
  logic [63:0]     pat_high_r = '0;
  logic [MaskW-1:0] mask_r    = '0;
  logic [LenW-1:0] len_r      = '0;
  logic [CntW-1:0] limit_r    = 16'd1;

  // scan state of the predictor
  logic [7:0]      win_q [WinDepth];
  logic [PosW-1:0] pos_q   = '0;
  logic [CntW-1:0] found_q = '0;

  scan_out_t pending_results[$];
  scan_out_t step_results[$];
  stim_row_t directed_rows[$];

  int err_count      = 0;
  int items_sent     = 0;
  int matches_seen   = 0;
  int summaries_seen = 0;
  int hold_cycles    = 0;
  bit send_steady    = 1'b0;
  bit recv_steady    = 1'b0;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic scan_out_t result_of(input logic kind, input logic [OffW-1:0] off,
                                          input logic [CntW-1:0] cnt, input logic last);
    scan_out_t r;
    r.result_kind  = kind;
    r.match_offset = off;
    r.match_count  = cnt;
    r.last_result  = last;
    return r;
  endfunction

  function automatic logic [7:0] pat_byte(input int j);
    if (j < 8) return pat_low_r[8*j +: 8];
    return pat_high_r[8*(j-8) +: 8];
  endfunction

  // does the masked pattern end at the byte now arriving
  function automatic bit pattern_ends_here(input logic [7:0] cur);
    int          len;
    int          back;
    bit          any;
    logic [7:0]  b;
    logic [63:0] p;
    len = int'(len_r);
    any = 1'b0;
    p   = 64'(pos_q);
    if (len == 0 || len > MaxPattern) return 1'b0;
    if (p + 64'd1 < 64'(len)) return 1'b0;
    for (int j = 0; j < len; j++) begin
      back = len - 1 - j;
      b = (back == 0) ? cur : win_q[back-1];
      if (mask_r[j]) begin
        any = 1'b1;
        if (b != pat_byte(j)) return 1'b0;
      end
    end
    return any;
  endfunction

  function automatic void clear_scan();
    foreach (win_q[k]) win_q[k] = 8'h00;
    pos_q   = '0;
    found_q = '0;
  endfunction

  // results caused by one byte, left in step_results
  function automatic void predict_step(input scan_in_t it);
    logic [63:0] p;
    logic [63:0] start;
    step_results.delete();
    p = 64'(pos_q);
    if (pattern_ends_here(it.data_byte)) begin
      start = p + 64'd1 - 64'(len_r);
      if (start < (64'd1 << OffsetBits) && found_q < limit_r) begin
        found_q = found_q + 1'b1;
        step_results.push_back(result_of(KindMatch, start[OffW-1:0], found_q,
                                         !it.end_of_buffer));
      end
    end
    for (int k = WinDepth - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = it.data_byte;
    if (p < (64'd1 << (OffsetBits + 1)) - 64'd1) pos_q = pos_q + 1'b1;
    if (it.end_of_buffer) begin
      step_results.push_back(result_of(KindSummary, '0, found_q, 1'b1));
      clear_scan();
    end
  endfunction

  // register write, block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_PAT_LOW:  pat_low_r  = v;
      CFG_PAT_HIGH: pat_high_r = v;
      CFG_MASK:     mask_r     = v[MaskW-1:0];
      CFG_LENGTH:   len_r      = v[LenW-1:0];
      CFG_LIMIT:    limit_r    = v[CntW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // offer one item, wait for it to be taken, then log what it should cause
  task automatic send_item(input scan_in_t it, input int typed_n,
                           input scan_out_t r0, input scan_out_t r1);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    predict_step(it);
    if (typed_n < 0) begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end else begin
      if (typed_n > 0) pending_results.push_back(r0);
      if (typed_n > 1) pending_results.push_back(r1);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  // sender stops until every expected result is out, then lets the pipe settle
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic void add_write(input cfg_idx_e idx, input logic [63:0] v);
    stim_row_t row;
    row.kind    = ROW_WRITE;
    row.idx     = idx;
    row.value   = v;
    row.item    = '0;
    row.typed_n = 0;
    row.res0    = '0;
    row.res1    = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_byte(input logic [7:0] d, input logic eob, input int typed_n,
                                   input scan_out_t r0, input scan_out_t r1);
    stim_row_t row;
    row.kind    = ROW_BYTE;
    row.idx     = CFG_PAT_LOW;
    row.value   = '0;
    row.item.data_byte     = d;
    row.item.end_of_buffer = eob;
    row.typed_n = typed_n;
    row.res0    = r0;
    row.res1    = r1;
    directed_rows.push_back(row);
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_results
    scan_out_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result with nothing pending: kind %0b off %0d cnt %0d",
                             out_item_o.result_kind, out_item_o.match_offset,
                             out_item_o.match_count));
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.result_kind !== want.result_kind)
          flag_error($sformatf("result_kind %0b, wanted %0b",
                               out_item_o.result_kind, want.result_kind));
        if (out_item_o.match_offset !== want.match_offset)
          flag_error($sformatf("match_offset %0d, wanted %0d",
                               out_item_o.match_offset, want.match_offset));
        if (out_item_o.match_count !== want.match_count)
          flag_error($sformatf("match_count %0d, wanted %0d",
                               out_item_o.match_count, want.match_count));
        if (out_item_o.last_result !== want.last_result)
          flag_error($sformatf("last_result %0b, wanted %0b",
                               out_item_o.last_result, want.last_result));
        if (want.result_kind == KindSummary) summaries_seen++;
        else matches_seen++;
      end
    end
  end

  // result receiver with random stalls and an optional long hold-off
  initial begin : receiver
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = recv_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pop <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (!empty) break;
      end
      @(negedge clk_i);
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    scan_in_t  it;
    scan_out_t none;
    int        n;
    int        k;
    int        r;
    int        bad;
    int        len;
    int        guard;
    int        phase;
    logic [7:0] b;

    none = '0;
    clear_scan();

    // directed table
    // after reset: length 0, so only an empty summary
    add_byte(8'h00, 1'b1, 1, result_of(KindSummary, 0, 0, 1'b1), none);
    // three-byte pattern, full mask, widest limit
    add_write(CFG_PAT_LOW,  64'h0000_0000_00CC_BBAA);
    add_write(CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_write(CFG_MASK,     64'h0007);
    add_write(CFG_LENGTH,   64'd3);
    add_write(CFG_LIMIT,    64'hFFFF);
    // too few bytes until the third
    add_byte(8'hAA, 1'b0, 0, none, none);
    add_byte(8'hBB, 1'b0, 0, none, none);
    add_byte(8'hCC, 1'b0, 1, result_of(KindMatch, 0, 1, 1'b1), none);
    // match on the end-of-buffer byte: match then summary
    add_byte(8'hAA, 1'b0, -1, none, none);
    add_byte(8'hBB, 1'b0, -1, none, none);
    add_byte(8'hCC, 1'b1, 2, result_of(KindMatch, 3, 2, 1'b0),
             result_of(KindSummary, 0, 2, 1'b1));
    // empty mask
    add_write(CFG_MASK, 64'h0000);
    add_byte(8'hAA, 1'b0, 0, none, none);
    add_byte(8'hBB, 1'b0, 0, none, none);
    add_byte(8'hCC, 1'b1, 1, result_of(KindSummary, 0, 0, 1'b1), none);
    // mask bits only above the length are ignored
    add_write(CFG_MASK, 64'hFFF8);
    add_byte(8'hAA, 1'b0, 0, none, none);
    add_byte(8'hBB, 1'b0, 0, none, none);
    add_byte(8'hCC, 1'b1, 1, result_of(KindSummary, 0, 0, 1'b1), none);
    // wildcard in the middle
    add_write(CFG_MASK, 64'h0005);
    add_byte(8'hAA, 1'b0, -1, none, none);
    add_byte(8'h12, 1'b0, -1, none, none);
    add_byte(8'hCC, 1'b1, -1, none, none);
    // overlong pattern disables matching
    add_write(CFG_LENGTH, 64'd17);
    add_write(CFG_MASK,   64'hFFFF);
    add_byte(8'h00, 1'b1, 1, result_of(KindSummary, 0, 0, 1'b1), none);
    // single byte pattern, limit of one reached
    add_write(CFG_PAT_LOW, 64'h0000_0000_0000_00FF);
    add_write(CFG_LENGTH,  64'd1);
    add_write(CFG_MASK,    64'h0001);
    add_write(CFG_LIMIT,   64'd1);
    add_byte(8'hFF, 1'b0, 1, result_of(KindMatch, 0, 1, 1'b1), none);
    add_byte(8'hFF, 1'b1, 1, result_of(KindSummary, 0, 1, 1'b1), none);
    // zero limit reports nothing
    add_write(CFG_LIMIT, 64'd0);
    add_byte(8'hFF, 1'b1, 1, result_of(KindSummary, 0, 0, 1'b1), none);

    // hold reset, then release it
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].item, directed_rows[i].typed_n,
                  directed_rows[i].res0, directed_rows[i].res1);
      end
    end

    // random phases; scans often run across phase boundaries, so writes land mid-scan
    phase = 0;
    while (items_sent < ItemTarget) begin
      wait_drained();
      send_steady = 1'b0;
      recv_steady = 1'b0;

      if (phase == 3) begin
        // receiver holds off while the sender streams one match per item
        write_reg(CFG_PAT_LOW, 64'h0000_0000_0000_005A);
        write_reg(CFG_LENGTH,  64'd1);
        write_reg(CFG_MASK,    64'h0001);
        write_reg(CFG_LIMIT,   64'hFFFF);
        send_steady = 1'b1;
        hold_cycles = 80;
        for (k = 0; k < 40; k++) begin
          it.data_byte     = 8'h5A;
          it.end_of_buffer = (k == 39);
          send_item(it, -1, none, none);
        end
      end else begin
        // new register settings
        if (phase == 0 || $urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 5);
          write_reg(CFG_PAT_LOW, (r == 0) ? 64'h0 : (r == 1) ? ~64'h0 :
                                 {$urandom, $urandom});
        end
        if (phase == 0 || $urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 5);
          write_reg(CFG_PAT_HIGH, (r == 0) ? 64'h0 : (r == 1) ? ~64'h0 :
                                  {$urandom, $urandom});
        end
        if (phase == 0 || $urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 7);
          write_reg(CFG_MASK, (r == 0) ? 64'h0 : (r == 1) ? 64'hFFFF :
                              64'($urandom_range(0, 16'hFFFF)));
        end
        if (phase == 0 || $urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 9);
          write_reg(CFG_LENGTH, (r == 0) ? 64'd0 : (r == 1) ? 64'($urandom_range(17, 31)) :
                                (r == 2) ? 64'd16 : 64'($urandom_range(1, 16)));
        end
        if (phase == 0 || $urandom_range(0, 1) == 0) begin
          r = $urandom_range(0, 5);
          write_reg(CFG_LIMIT, (r == 0) ? 64'd0 : (r == 1) ? 64'd1 :
                               (r == 2) ? 64'hFFFF : (r == 3) ? 64'($urandom_range(2, 4)) :
                               64'($urandom_range(0, 16'hFFFF)));
        end
        send_steady = ($urandom_range(0, 4) == 0);
        recv_steady = ($urandom_range(0, 4) == 0);

        // mostly planted pattern occurrences, some broken, the rest noise
        len = int'(len_r);
        n = $urandom_range(15, 70);
        k = 0;
        while (k < n) begin
          r = $urandom_range(0, 9);
          if (r < 5 && len >= 1 && len <= MaxPattern) begin
            bad = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int j = 0; j < len; j++) begin
              b = mask_r[j] ? pat_byte(j) : 8'($urandom);
              if (j == bad) b = b ^ (8'd1 << $urandom_range(0, 7));
              it.data_byte     = b;
              it.end_of_buffer = (j == len - 1) && ($urandom_range(0, 7) == 0);
              send_item(it, -1, none, none);
              k++;
            end
          end else begin
            it.data_byte     = (r == 9) ? pat_byte($urandom_range(0, 15)) : 8'($urandom);
            it.end_of_buffer = ($urandom_range(0, 19) == 0);
            send_item(it, -1, none, none);
            k++;
          end
        end
      end
      phase++;
    end

    // drain with a bound, then settle
    push <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d bytes over %0d setting phases", items_sent, phase);
    $display("checked %0d match reports and %0d scan summaries", matches_seen, summaries_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mbps_pkg.sv
rtl/mbps_front.sv
rtl/mbps_queue.sv
rtl/mbps_back.sv
rtl/masked_byte_pattern_scanner_unit.sv
rtl/mbps_checker.sv
tb/masked_byte_pattern_scanner_unit_test.sv
